// ===== design/plt_pkg.sv =====
// Shared types and constants for the positional list store.
// Used by plt_ctrl, plt_dp and positional_list_store; depends on nothing.
package plt_pkg;

   // Fixed request/response field widths
   localparam int CMD_W  = 2;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

   // Response status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_FETCH,
      S_LOOP,
      S_SH_WR,
      S_PUT,
      S_FINISH
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic load;      // latch request, check it
      logic rd_idx;    // read entry at the request position
      logic rd_next;   // read the neighbor of the shift cursor
      logic wr_shift;  // write read data at the cursor
      logic wr_put;    // write new value at the request position
      logic capture;   // keep read data as the response value
      logic step;      // move the cursor one place
      logic finish;    // load response, commit length
   } ctrl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic err;
      logic is_insert;
      logic is_get;
      logic more;       // another entry still to move
      logic slot_free;  // response register can take a result
   } dp_status_type;

endpackage

// ===== design/plt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/plt_ctrl.sv =====
// Sequencer for the positional list store: walks each request through
// check, fetch, shift and put steps. Depends on plt_pkg.
module plt_ctrl
   import plt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_START;
         end
         S_START: begin
            if (status.err)            state_in = S_FINISH;
            else if (status.is_insert) state_in = S_LOOP;
            else                       state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = status.is_get ? S_FINISH : S_LOOP;
         end
         S_LOOP: begin
            if (status.more)           state_in = S_SH_WR;
            else if (status.is_insert) state_in = S_PUT;
            else                       state_in = S_FINISH;
         end
         S_SH_WR:  state_in = S_LOOP;
         S_PUT:    state_in = S_FINISH;
         S_FINISH: begin
            if (status.slot_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_START: begin
            cmd.rd_idx = !status.err && !status.is_insert;
         end
         S_FETCH: begin
            cmd.capture = 1'b1;
         end
         S_LOOP: begin
            cmd.rd_next = status.more;
         end
         S_SH_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.step     = 1'b1;
         end
         S_PUT: begin
            cmd.wr_put = 1'b1;
         end
         S_FINISH: begin
            cmd.finish = status.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== design/plt_dp.sv =====
// Datapath of the positional list store: request checks, shift cursor,
// entry RAM, length counter and response register. Depends on plt_pkg, plt_ram.
module plt_dp
   import plt_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dp_status_type           status,
   input  logic [CMD_W-1:0]        req_command,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [DATA_W-1:0] req_new_value,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic                    rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [LEN_W-1:0]        rsp_list_length
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int EXT_W = ELEM_WIDTH + DATA_W;

   logic [CMD_W-1:0]      cmd_ff;
   logic                  err_ff;
   logic [AW-1:0]         idx_ff;
   logic [AW-1:0]         cur_ff;
   logic [ELEM_WIDTH-1:0] val_ff;
   logic [DATA_W-1:0]     rdval_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_status_ff;
   logic [DATA_W-1:0]     rsp_value_ff;
   logic [LEN_W-1:0]      rsp_len_ff;

   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic                  ins_ok;
   logic                  acc_ok;
   logic                  err_in;
   logic [AW-1:0]         idx_in;
   logic [EXT_W-1:0]      val_wide;
   logic [EXT_W-1:0]      rd_wide;
   logic [AW-1:0]         next_addr;
   logic                  is_insert;
   logic                  more;
   logic                  slot_free;
   logic [ELEM_WIDTH-1:0] rd_data;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [ELEM_WIDTH-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;

   // Request checks against the current length
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign ins_ok  = (cnt_ext < CMP_W'(DEPTH)) && (pos_ext != '0)
                    && (pos_ext <= cnt_ext + CMP_W'(1));
   assign acc_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

   always_comb begin
      case (req_command)
         CMD_INSERT: err_in = !ins_ok;
         CMD_DELETE: err_in = !acc_ok;
         CMD_GET:    err_in = !acc_ok;
         default:    err_in = 1'b1;
      endcase
   end

   assign idx_in   = AW'(req_position - POS_W'(1));
   assign val_wide = EXT_W'($unsigned(req_new_value));
   assign rd_wide  = EXT_W'(rd_data);

   assign is_insert = (cmd_ff == CMD_INSERT);
   // Insert moves entries up, walking down from the tail; delete walks up
   assign next_addr = is_insert ? (cur_ff - AW'(1)) : (cur_ff + AW'(1));
   assign more      = is_insert ? (cur_ff > idx_ff)
                                : ((CNT_W'(cur_ff) + CNT_W'(1)) < count_ff);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign status.err       = err_ff;
   assign status.is_insert = is_insert;
   assign status.is_get    = (cmd_ff == CMD_GET);
   assign status.more      = more;
   assign status.slot_free = slot_free;

   always_comb begin
      count_in = count_ff;
      if (!err_ff) begin
         case (cmd_ff)
            CMD_INSERT: count_in = count_ff + CNT_W'(1);
            CMD_DELETE: count_in = count_ff - CNT_W'(1);
            default:    count_in = count_ff;
         endcase
      end
   end

   // Request and cursor registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         err_ff <= err_in;
         idx_ff <= idx_in;
         val_ff <= val_wide[ELEM_WIDTH-1:0];
         cur_ff <= (req_command == CMD_INSERT) ? count_ff[AW-1:0] : idx_in;
      end else if (cmd.step) begin
         cur_ff <= next_addr;
      end
      if (cmd.capture) begin
         rdval_ff <= rd_wide[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= err_ff ? STATUS_ERROR : STATUS_OK;
         rsp_value_ff  <= (err_ff || is_insert) ? '0 : rdval_ff;
         rsp_len_ff    <= LEN_W'(count_in);
      end
   end

   // Entry store
   assign ram_wr_en   = cmd.wr_shift || cmd.wr_put;
   assign ram_wr_addr = cmd.wr_put ? idx_ff : cur_ff;
   assign ram_wr_data = cmd.wr_put ? val_ff : rd_data;
   assign ram_rd_en   = cmd.rd_idx || cmd.rd_next;
   assign ram_rd_addr = cmd.rd_next ? next_addr : idx_ff;

   plt_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_list_length = rsp_len_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list length above depth");

   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> slot_free)
      else $error("response loaded over an unaccepted one");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.finish |=> $stable(count_ff))
      else $error("length changed outside response load");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_ERROR) |-> rsp_value_ff == '0)
      else $error("error response carries data");

endmodule

// ===== design/positional_list_store.sv =====
// Positional list store, top level: stream ports, sequencer and datapath.
// Depends on plt_pkg, plt_ctrl, plt_dp (and plt_ram through plt_dp).
//
// A bounded ordered list of DEPTH signed words addressed by 1-based position.
// insert places new_value at the position and moves later entries up, delete
// removes and returns the entry and moves later entries down, get returns the
// entry. A full list, an empty list, a bad position or an unknown command
// gives status error, read value zero and leaves the list unchanged; every
// response carries the length after the request. Entries live in a single
// RAM with one write and one registered read port, so each moved entry is
// read and then written one place over. Requests are taken one at a time.
// A finished response sits in an output register, so the next request is
// taken and worked on while the previous response waits for rsp_tready;
// the block only stalls at the end of that next request if the response
// is still not taken.
module positional_list_store
   import plt_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [1:0] command, [8:2] position, [40:9] new_value, [47:41] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // rsp_tdata: [0] status, [32:1] read_value, [39:33] list_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata
);

   ctrl_cmd_type         cmd;
   dp_status_type        status;
   logic [CMD_W-1:0]     req_command;
   logic [POS_W-1:0]     req_position;
   logic signed [DATA_W-1:0] req_new_value;
   logic                 rsp_status;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [LEN_W-1:0]     rsp_list_length;

   // Request unpacking
   assign req_command   = req_tdata[1:0];
   assign req_position  = req_tdata[8:2];
   assign req_new_value = req_tdata[40:9];

   plt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   plt_dp #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_list_length (rsp_list_length)
   );

   // Response packing
   assign rsp_tdata = {rsp_list_length, rsp_read_value, rsp_status};

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for positional_list_store: a queued request driver, a checking
// monitor and a behavioral list model that predicts every response.
// Depends on plt_pkg and the positional_list_store RTL.
module tb;
   import plt_pkg::*;

   localparam int LIST_DEPTH   = 64;
   localparam int RANDOM_ITEMS = 1530;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 40;

   // the package leaves code three undefined: the block must reject it
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] new_value;
   } list_req_type;

   typedef struct packed {
      logic                     status;
      logic signed [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]         list_length;
   } list_rsp_type;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN, MIX_NOISE} mix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // [1:0] command, [8:2] position, [40:9] new_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [0] status, [32:1] read_value, [39:33] list_length

   // list model state
   logic [DATA_W-1:0] list_words [LIST_DEPTH];
   int                list_len = 0;

   list_req_type queued_requests [$];
   list_rsp_type due_responses [$];
   list_req_type offered_req;
   int        burst_left = 0;
   int        gap_left = 0;
   int        plan_len = 0;
   int        fail_count = 0;
   int        idle_cycles = 0;
   int        hold_asks = 0;
   int        hold_seen = 0;
   int        hold_left = 0;
   int        rx_mode = 0;
   int        rx_mode_left = 0;
   logic [7:0] rx_pattern = 8'b1011_0010;

   positional_list_store #(
      .DEPTH      (LIST_DEPTH),
      .ELEM_WIDTH (DATA_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Applies one request to the list model and returns the response it owes.
   function automatic list_rsp_type apply_list_op(list_req_type rq);
      list_rsp_type r;
      int        p;
      int        j;
      r.status      = STATUS_ERROR;
      r.read_value  = '0;
      p = int'(rq.position);
      case (rq.command)
         CMD_INSERT: begin
            if (list_len < LIST_DEPTH && p >= 1 && p <= list_len + 1) begin
               for (j = list_len; j >= p; j--) list_words[j] = list_words[j-1];
               list_words[p-1] = rq.new_value;
               list_len++;
               r.status = STATUS_OK;
            end
         end
         CMD_DELETE: begin
            if (p >= 1 && p <= list_len) begin
               r.read_value = list_words[p-1];
               for (j = p - 1; j + 1 < list_len; j++) list_words[j] = list_words[j+1];
               list_len--;
               r.status = STATUS_OK;
            end
         end
         CMD_GET: begin
            if (p >= 1 && p <= list_len) begin
               r.read_value = list_words[p-1];
               r.status     = STATUS_OK;
            end
         end
         default: ;
      endcase
      r.list_length = LEN_W'(list_len);
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Builds a random request; mostly legal positions for the planned length,
   // with edge positions and pure noise mixed in.
   function automatic list_req_type plan_request(mix_type mix);
      list_req_type rq;
      int        ins_pct;
      int        roll;
      rq.new_value = pick_value();
      if (mix == MIX_NOISE || $urandom_range(0, 99) < 8) begin
         rq.command  = CMD_W'($urandom_range(0, 3));
         rq.position = POS_W'($urandom_range(0, 127));
      end else begin
         case (mix)
            MIX_GROW:   ins_pct = 75;
            MIX_SHRINK: ins_pct = 20;
            default:    ins_pct = 45;
         endcase
         roll = $urandom_range(0, 99);
         if (roll < ins_pct) begin
            rq.command  = CMD_INSERT;
            rq.position = POS_W'($urandom_range(1, plan_len + 1));
         end else begin
            rq.command  = (roll < ins_pct + (100 - ins_pct) / 2) ? CMD_DELETE : CMD_GET;
            rq.position = (plan_len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, plan_len));
         end
         // probe the top of the list: last entry, one past, two past
         if ($urandom_range(0, 9) == 0)
            rq.position = POS_W'(plan_len + int'($urandom_range(0, 2)));
      end
      if (rq.command == CMD_INSERT && plan_len < LIST_DEPTH && rq.position >= 1 &&
          rq.position <= plan_len + 1)
         plan_len++;
      else if (rq.command == CMD_DELETE && rq.position >= 1 && rq.position <= plan_len)
         plan_len--;
      return rq;
   endfunction

   task automatic push_req(logic [CMD_W-1:0] cmd, int pos, logic [DATA_W-1:0] value);
      list_req_type rq;
      rq.command   = cmd;
      rq.position  = POS_W'(pos);
      rq.new_value = value;
      queued_requests.push_back(rq);
   endtask

   task automatic wait_all_done();
      while (queued_requests.size() != 0 || req_tvalid || due_responses.size() != 0)
         @(posedge clock);
   endtask

   // Driver: bursts of requests with random gaps; prediction at acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_responses.push_back(apply_list_op(offered_req));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               offered_req = queued_requests.pop_front();
               req_tdata  <= {7'd0, offered_req.new_value, offered_req.position,
                              offered_req.command};
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: response checking plus the receiver's stall pattern.
   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status      = rsp_tdata[0];
            got.read_value  = rsp_tdata[32:1];
            got.list_length = rsp_tdata[39:33];
            if (due_responses.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response: status %0d value %0d length %0d",
                           got.status, got.read_value, got.list_length);
            end else begin
               want = due_responses.pop_front();
               if (got.status !== want.status || got.read_value !== want.read_value ||
                   got.list_length !== want.list_length) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("response mismatch: expected status %0d value %0d length %0d, %s",
                              want.status, want.read_value, want.list_length,
                              $sformatf("got status %0d value %0d length %0d",
                                        got.status, got.read_value, got.list_length));
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_asks != hold_seen) begin
            // long hold-off: the block backs up and must stall its request side
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode      = $urandom_range(0, 3);
               rx_mode_left = $urandom_range(20, 200);
            end else begin
               rx_mode_left--;
            end
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: begin
                  rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
                  rsp_tready <= rx_pattern[0];
               end
            endcase
         end
      end
   end

   // Watchdog: cycles without any handshake.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("positional_list_store verification failed");
         $finish;
      end
   end

   initial begin
      int   planned;
      int   phase_no;
      int   phase_len;
      mix_type mix;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, bad positions, head/middle/tail moves, extremes
      push_req(CMD_GET,    1,   $urandom);      // get on empty
      push_req(CMD_DELETE, 1,   $urandom);      // delete on empty
      push_req(CMD_INSERT, 0,   32'h1234_5678); // position zero
      push_req(CMD_INSERT, 2,   32'h1234_5678); // beyond length + 1
      push_req(CMD_INSERT, 1,   32'h7FFF_FFFF);
      push_req(CMD_INSERT, 1,   32'h8000_0000); // at head
      push_req(CMD_INSERT, 3,   32'hFFFF_FFFF); // append
      push_req(CMD_INSERT, 2,   32'h0000_0000); // in the middle, length 4
      push_req(CMD_INSERT, 127, 32'hA5A5_5A5A); // all position bits set
      push_req(CMD_INSERT, 6,   32'h0F0F_F0F0); // length + 2
      push_req(CMD_GET,    0,   $urandom);
      push_req(CMD_GET,    5,   $urandom);      // past the end
      push_req(CMD_GET,    1,   $urandom);
      push_req(CMD_GET,    4,   $urandom);
      push_req(CMD_GET,    2,   $urandom);
      push_req(CMD_UNUSED, 1,   32'hFFFF_FFFF); // undefined command
      push_req(CMD_DELETE, 0,   $urandom);
      push_req(CMD_DELETE, 5,   $urandom);
      push_req(CMD_DELETE, 2,   $urandom);      // middle
      push_req(CMD_DELETE, 3,   $urandom);      // tail
      push_req(CMD_DELETE, 1,   $urandom);      // head
      push_req(CMD_GET,    1,   $urandom);
      push_req(CMD_DELETE, 1,   $urandom);      // back to empty
      push_req(CMD_DELETE, 1,   $urandom);
      wait_all_done();
      plan_len = 0;

      planned  = 0;
      phase_no = 0;
      while (planned < RANDOM_ITEMS) begin
         if (phase_no == 0) begin
            mix       = MIX_GROW;
            phase_len = 160;
         end else begin
            case ($urandom_range(0, 5))
               0, 1:    mix = MIX_GROW;
               2, 3:    mix = MIX_SHRINK;
               4:       mix = MIX_CHURN;
               default: mix = MIX_NOISE;
            endcase
            phase_len = $urandom_range(20, 120);
         end
         if (phase_len > RANDOM_ITEMS - planned) phase_len = RANDOM_ITEMS - planned;
         for (int k = 0; k < phase_len; k++) queued_requests.push_back(plan_request(mix));
         planned += phase_len;
         if (phase_no == 0) begin
            @(posedge clock);
            hold_asks <= hold_asks + 1;
         end
         if (phase_no == 0 || $urandom_range(0, 3) == 0) wait_all_done();
         phase_no++;
      end

      wait_all_done();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && due_responses.size() == 0)
         $display("positional_list_store verification clean");
      else
         $display("positional_list_store verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/plt_pkg.sv
design/plt_ram.sv
design/plt_ctrl.sv
design/plt_dp.sv
design/positional_list_store.sv
test/tb.sv
